// ----- sv/scpi_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted colour palette indexer package
// Request and status codes, pixel constants and the per-cell flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package scpi_pkg;

  localparam int COLOUR_W = 32;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int READ_SPAN = 256;

  localparam logic [COLOUR_W-1:0] ALPHA_MASK  = 32'hF000_0000;
  localparam logic [COLOUR_W-1:0] TRANSPARENT = 32'hFFFF_FFFF;
  localparam logic [COLOUR_W-1:0] RGB_MASK    = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    REQ_LEARN = 2'd0,
    REQ_MAP   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } scpi_req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } scpi_status_t;

  typedef struct packed {
    logic lt;
    logic at;
    logic eq;
    logic rd_hit;
  } scpi_cell_flags_t;

  function automatic logic [COLOUR_W-1:0] normalise(input logic [COLOUR_W-1:0] px);
    logic [COLOUR_W-1:0] res;
    if ((px & ALPHA_MASK) != '0) begin
      res = TRANSPARENT;
    end else begin
      res = px & RGB_MASK;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/scpi_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted colour palette indexer cell
// Holds one palette entry, compares it with the request colour and shifts
// the entry from its lower neighbor when a colour is inserted below it.
// ----------------------------------------------------------------------------
`default_nettype none

module scpi_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  wire logic                          clk,
  input  wire logic                          shift_en,
  input  wire logic [scpi_pkg::COLOUR_W-1:0] col,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic                          prev_lt,
  input  wire logic [scpi_pkg::COLOUR_W-1:0] prev_entry,
  input  wire logic [scpi_pkg::INDEX_W-1:0]  rd_index,
  output logic      [scpi_pkg::COLOUR_W-1:0] entry,
  output scpi_pkg::scpi_cell_flags_t         flags
);

  localparam bit READABLE = (CELL_IDX < scpi_pkg::READ_SPAN);

  logic [scpi_pkg::COLOUR_W-1:0] entry_r;
  logic [scpi_pkg::COLOUR_W-1:0] entry_nxt;
  logic                          active;
  logic                          lt;

  assign active = (CNT_W'(CELL_IDX) < count);
  assign lt     = active && (entry_r < col);

  always_comb begin
    flags.lt     = lt;
    flags.at     = prev_lt && !lt;
    flags.eq     = prev_lt && !lt && active && (entry_r == col);
    flags.rd_hit = READABLE && active
                   && (rd_index == scpi_pkg::INDEX_W'(CELL_IDX));
  end

  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) begin
      if (!prev_lt) begin
        entry_nxt = prev_entry;
      end else if (!lt) begin
        entry_nxt = col;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ----- sv/sorted_colour_palette_indexer.sv -----
// ----------------------------------------------------------------------------
// Sorted colour palette indexer
// Keeps an ascending table of distinct colours in a row of compare cells.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low.
// Busy stays low, so one transaction can be issued on every clock cycle.
// The request is registered with its pixel already normalized; in the next
// cycle every cell compares its entry with that colour in parallel, the
// lower-bound position, match and read select are gathered from the row, and
// on an insert each cell above the position takes its neighbor's entry.
// The result is on the out_ ports with out_valid high for one cycle, once the
// request and output registers have both captured it; the receiver must take it
// at the second rising edge after acceptance.
// Learn and map requests return the sorted index, read requests return one
// entry, and clear empties the table and the overflow flag.
// Synchronous reset empties the table, clears the overflow flag and drops
// any request in flight. Table entries themselves are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_colour_palette_indexer #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_pixel_colour,
  input  wire logic [7:0]  in_entry_index,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_colour_index,
  output logic [31:0]      out_entry_colour,
  output logic [8:0]       out_colour_count,
  output logic             out_overflowed
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                          req_vld_r;
  scpi_pkg::scpi_req_t           req_type_r;
  logic [scpi_pkg::COLOUR_W-1:0] req_col_r;
  logic [scpi_pkg::INDEX_W-1:0]  req_idx_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             overflow_r;
  logic             overflow_nxt;

  logic [scpi_pkg::COLOUR_W-1:0] cell_entry [TABLE_DEPTH];
  scpi_pkg::scpi_cell_flags_t    cell_flags [TABLE_DEPTH];
  logic                          shift_en;

  logic                          found;
  logic                          rd_hit;
  logic [scpi_pkg::INDEX_W-1:0]  pos_idx;
  logic [scpi_pkg::COLOUR_W-1:0] rd_data;
  logic                          full;

  scpi_pkg::scpi_status_t        status_nxt;
  logic [scpi_pkg::INDEX_W-1:0]  cidx_nxt;
  logic [scpi_pkg::COLOUR_W-1:0] ecol_nxt;

  logic                          out_valid_r;
  scpi_pkg::scpi_status_t        out_status_r;
  logic [scpi_pkg::INDEX_W-1:0]  out_cidx_r;
  logic [scpi_pkg::COLOUR_W-1:0] out_ecol_r;
  logic [scpi_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_ovf_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_type_r <= scpi_pkg::scpi_req_t'(in_req_type);
      req_col_r  <= scpi_pkg::normalise(in_pixel_colour);
      req_idx_r  <= in_entry_index;
    end
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        scpi_cell #(
          .CELL_IDX (g),
          .CNT_W    (CNT_W)
        ) u_cell (
          .clk        (clk),
          .shift_en   (shift_en),
          .col        (req_col_r),
          .count      (count_r),
          .prev_lt    (1'b1),
          .prev_entry ('0),
          .rd_index   (req_idx_r),
          .entry      (cell_entry[g]),
          .flags      (cell_flags[g])
        );
      end else begin : g_rest
        scpi_cell #(
          .CELL_IDX (g),
          .CNT_W    (CNT_W)
        ) u_cell (
          .clk        (clk),
          .shift_en   (shift_en),
          .col        (req_col_r),
          .count      (count_r),
          .prev_lt    (cell_flags[g-1].lt),
          .prev_entry (cell_entry[g-1]),
          .rd_index   (req_idx_r),
          .entry      (cell_entry[g]),
          .flags      (cell_flags[g])
        );
      end
    end
  endgenerate

  always_comb begin
    found   = 1'b0;
    rd_hit  = 1'b0;
    pos_idx = '0;
    rd_data = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found  = found | cell_flags[i].eq;
      rd_hit = rd_hit | cell_flags[i].rd_hit;
      if (cell_flags[i].at) begin
        pos_idx = pos_idx | scpi_pkg::INDEX_W'(i);
      end
      if (cell_flags[i].rd_hit) begin
        rd_data = rd_data | cell_entry[i];
      end
    end
  end

  assign full = (count_r == CNT_W'(TABLE_DEPTH));

  always_comb begin
    shift_en     = 1'b0;
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    status_nxt   = scpi_pkg::ST_OK;
    cidx_nxt     = '0;
    ecol_nxt     = '0;
    if (req_vld_r) begin
      case (req_type_r)
        scpi_pkg::REQ_LEARN: begin
          if (found) begin
            cidx_nxt = pos_idx;
          end else if (full) begin
            status_nxt   = scpi_pkg::ST_FULL;
            overflow_nxt = 1'b1;
          end else begin
            shift_en   = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
            status_nxt = scpi_pkg::ST_INSERTED;
            cidx_nxt   = pos_idx;
          end
        end
        scpi_pkg::REQ_MAP: begin
          if (found) begin
            cidx_nxt = pos_idx;
          end else begin
            status_nxt = scpi_pkg::ST_NOT_FOUND;
          end
        end
        scpi_pkg::REQ_READ: begin
          if (rd_hit) begin
            ecol_nxt = rd_data;
          end else begin
            status_nxt = scpi_pkg::ST_BAD_INDEX;
          end
        end
        scpi_pkg::REQ_CLEAR: begin
          count_nxt    = '0;
          overflow_nxt = 1'b0;
        end
        default: begin
          status_nxt = scpi_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= status_nxt;
    out_cidx_r   <= cidx_nxt;
    out_ecol_r   <= ecol_nxt;
    out_count_r  <= scpi_pkg::COUNT_W'(count_nxt);
    out_ovf_r    <= overflow_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_colour_index = out_cidx_r;
  assign out_entry_colour = out_ecol_r;
  assign out_colour_count = out_count_r;
  assign out_overflowed   = out_ovf_r;

endmodule

`default_nettype wire
